[hdl/bilinear_texture_sampler_unit_defines.svh]
// Assertion macros for the texture sampler back end (bts_back).
// No dependencies.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_DEFINES_SVH

// Property that must hold on every clock once out of reset.
`define BTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bts_pkg.sv]
// Package for the bilinear texture sampler: sizes, types, helpers.
// No dependencies.
package bts_pkg;
  localparam int MAX_DIM_DEF     = 64;
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 12;
  localparam int TEXEL_W = 32;
  localparam int COORD_W = 16;
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
  localparam logic CFG_WIDTH   = 1'b0;
  localparam logic CFG_HEIGHT  = 1'b1;
endpackage

[hdl/bts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[hdl/bts_front.sv]
// Front end: takes every transfer in order, computes texel addresses and
// fractions for samples and passes write items along in order with them.
// Depends on bts_pkg.
module bts_front import bts_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int AW        = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [IDX_W-1:0]       in_texel_index,
  input  logic [TEXEL_W-1:0]     in_texel_data,
  input  logic [COORD_W-1:0]     in_u,
  input  logic [COORD_W-1:0]     in_v,
  input  logic [CFG_W-1:0]       width,
  input  logic [CFG_W-1:0]       height,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic                   q_func,
  output logic [IDX_W-1:0]       q_idx,
  output logic [TEXEL_W-1:0]     q_data,
  output logic [4*AW-1:0]        q_addr,
  output logic [FRAC_BITS:0]     q_fx,
  output logic [FRAC_BITS:0]     q_fy
);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int PW = COORD_W + DW + FRAC_BITS + 2;
  localparam int AWW = 2 * DW + 2;

  logic [DW-1:0] w_eff, h_eff;
  logic [DW-1:0] x0, x1, y0, y1;
  logic signed [FRAC_BITS+1:0] fx_s, fy_s;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_func_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [TEXEL_W-1:0] s1_data_r;
  logic [DW-1:0] s1_x0_r, s1_x1_r, s1_y0_r, s1_y1_r, s1_w_r;
  logic [FRAC_BITS:0] s1_fx_r, s1_fy_r;
  logic advance;

  function automatic logic [DW-1:0] eff(input logic [CFG_W-1:0] r);
    logic [DW+CFG_W-1:0] rr;
    rr = {{DW{1'b0}}, r};
    if (r == '0) return DW'(1);
    if (rr > (DW+CFG_W)'(MAX_DIM)) return DW'(MAX_DIM);
    return rr[DW-1:0];
  endfunction

  // Position = coord*size - half; index truncated toward zero, fraction signed.
  function automatic void locate(input logic [COORD_W-1:0] c, input logic [DW-1:0] sz,
                                 output logic [DW-1:0] i0, output logic [DW-1:0] i1,
                                 output logic signed [FRAC_BITS+1:0] f);
    logic [PW-1:0] prod, scaled;
    logic signed [PW:0] pos;
    logic [PW-1:0] ip;
    logic [DW-1:0] idx;
    prod = PW'(c) * PW'(sz);
    if (FRAC_BITS >= COORD_W) scaled = prod << (FRAC_BITS - COORD_W);
    else scaled = prod >> (COORD_W - FRAC_BITS);
    pos = $signed({1'b0, scaled}) - $signed((PW+1)'(1) <<< (FRAC_BITS - 1));
    if (pos < 0) begin
      idx = '0;
      f = (FRAC_BITS+2)'(pos);
    end else begin
      ip = PW'(pos) >> FRAC_BITS;
      f = $signed({2'b00, pos[FRAC_BITS-1:0]});
      idx = (ip > PW'(sz - 1'b1)) ? sz - 1'b1 : ip[DW-1:0];
    end
    if (PW'(pos >>> FRAC_BITS) > PW'(sz - 1'b1) && pos >= 0) idx = sz - 1'b1;
    i0 = idx;
    i1 = (idx + 1'b1 == sz) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    w_eff = eff(width);
    h_eff = eff(height);
    locate(in_u, w_eff, x0, x1, fx_s);
    locate(in_v, h_eff, y0, y1, fy_s);
  end

  assign advance  = !s1_valid_r || q_ready;
  assign in_ready = advance;
  // Writes travel the same path as samples so the store sees them in order.
  assign s1_valid_nxt = advance ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s1_valid_nxt;
    if (advance) begin
      s1_func_r <= in_func;
      s1_idx_r <= in_texel_index;
      s1_data_r <= in_texel_data;
      s1_x0_r <= x0; s1_x1_r <= x1; s1_y0_r <= y0; s1_y1_r <= y1;
      s1_w_r <= w_eff;
      s1_fx_r <= fx_s[FRAC_BITS:0];
      s1_fy_r <= fy_s[FRAC_BITS:0];
    end
  end

  // Stage 2 (combinational to queue): row*width + col addresses.
  function automatic logic [AW-1:0] addr(input logic [DW-1:0] r, input logic [DW-1:0] cl,
                                         input logic [DW-1:0] w);
    logic [AWW-1:0] a;
    a = AWW'(r) * AWW'(w) + AWW'(cl);
    return AW'(a);
  endfunction

  assign q_valid = s1_valid_r;
  assign q_func  = s1_func_r;
  assign q_idx   = s1_idx_r;
  assign q_data  = s1_data_r;
  assign q_addr  = {addr(s1_y1_r, s1_x1_r, s1_w_r), addr(s1_y1_r, s1_x0_r, s1_w_r),
                    addr(s1_y0_r, s1_x1_r, s1_w_r), addr(s1_y0_r, s1_x0_r, s1_w_r)};
  assign q_fx = s1_fx_r;
  assign q_fy = s1_fy_r;
endmodule

[hdl/bts_back.sv]
// Back end: queue, texel writes, four-port texel fetch, weight products and blend.
// Depends on bts_pkg, bts_ram and the assertion header.
`include "bilinear_texture_sampler_unit_defines.svh"
module bts_back import bts_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int AW          = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic                 q_func,
  input  logic [IDX_W-1:0]     q_idx,
  input  logic [TEXEL_W-1:0]   q_data,
  input  logic [4*AW-1:0]      q_addr,
  input  logic [FRAC_BITS:0]   q_fx,
  input  logic [FRAC_BITS:0]   q_fy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TEXEL_W-1:0]   out_color
);
  localparam int QD = 4;
  localparam int QW = $clog2(QD);
  localparam int XB = 4 * AW + 2 * (FRAC_BITS + 1);
  localparam int EW = 1 + IDX_W + TEXEL_W + XB;
  localparam int FW = FRAC_BITS + 2;
  localparam int WW = 2 * FW;
  localparam int AC = WW + 12;
  localparam int PIPE = 3;

  logic [EW-1:0] qmem_r [QD];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r, cnt_nxt, inflight;
  logic          deq;
  logic [EW-1:0] head;
  logic          head_func;
  logic [IDX_W-1:0]   head_idx;
  logic [TEXEL_W-1:0] head_data;
  logic          rd_en;
  logic [PIPE-1:0] vld_r;
  logic          adv;
  logic [TEXEL_W-1:0] tx [4];
  logic signed [FW-1:0] fx1_r, fy1_r;
  logic signed [WW-1:0] wt_r [4];
  logic [TEXEL_W-1:0] tx_r [4];
  logic [TEXEL_W-1:0] res_r;
  logic          wr_ok;
  // Output skid: two-entry buffer after the pipe.
  logic [TEXEL_W-1:0] ob_r [2];
  logic [1:0]    ob_cnt_r;
  logic          ob_wp_r, ob_rp_r;

  assign q_ready = cnt_r != (QW+1)'(QD);
  assign head = qmem_r[rp_r];
  assign head_func = head[EW-1];
  assign head_idx  = head[XB+TEXEL_W +: IDX_W];
  assign head_data = head[XB +: TEXEL_W];
  // Pipe stalls only when its last stage would push into a full buffer.
  assign adv = !vld_r[PIPE-1] || ob_cnt_r != 2'd2 || out_ready;
  assign deq = cnt_r != 0 && adv;
  assign rd_en = deq && head_func == FUNC_SAMPLE;
  assign inflight = cnt_r;
  assign cnt_nxt = cnt_r + (QW+1)'(q_valid && q_ready) - (QW+1)'(deq);
  assign wr_ok = deq && head_func == FUNC_WRITE &&
                 ({1'b0, head_idx} < (IDX_W+1)'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (q_valid && q_ready) wp_r <= wp_r + 1'b1;
      if (deq) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    if (q_valid && q_ready) qmem_r[wp_r] <= {q_func, q_idx, q_data, q_addr, q_fx, q_fy};
  end

  genvar g;
  for (g = 0; g < 4; g++) begin : g_bank
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram (
      .clk(clk), .we(wr_ok), .waddr($clog2(STORE_DEPTH)'(head_idx)), .wdata(head_data),
      .re(rd_en), .raddr($clog2(STORE_DEPTH)'(head[2*(FRAC_BITS+1)+g*AW +: AW])),
      .rdata(tx[g]));
  end

  // Pipe stage 0: fractions registered alongside RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[PIPE-2:0], rd_en};
    if (rd_en) begin
      fx1_r <= $signed({head[2*FRAC_BITS+1], head[2*FRAC_BITS+1:FRAC_BITS+1]});
      fy1_r <= $signed({head[FRAC_BITS], head[FRAC_BITS:0]});
    end
  end

  function automatic logic signed [WW-1:0] fmul(input logic signed [FW-1:0] a,
                                                 input logic signed [FW-1:0] b);
    logic signed [WW-1:0] p, m;
    p = WW'(a) * WW'(b);
    if (p < 0) begin
      m = -p;
      return -(m >>> FRAC_BITS);
    end
    return p >>> FRAC_BITS;
  endfunction

  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;

  // Stage 1: weights.
  always_ff @(posedge clk) begin
    if (adv && vld_r[0]) begin
      wt_r[0] <= fmul(ONE - fx1_r, ONE - fy1_r);
      wt_r[1] <= fmul(fx1_r, ONE - fy1_r);
      wt_r[2] <= fmul(ONE - fx1_r, fy1_r);
      wt_r[3] <= fmul(fx1_r, fy1_r);
      for (int k = 0; k < 4; k++) tx_r[k] <= tx[k];
    end
  end

  // Stage 2: blend per channel.
  always_ff @(posedge clk) begin
    logic signed [AC-1:0] acc;
    logic [AC-1:0] c;
    if (adv && vld_r[1]) begin
      for (int ch = 0; ch < 4; ch++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc = acc + AC'($signed({1'b0, tx_r[k][8*ch +: 8]})) * AC'(wt_r[k]);
        if (acc <= 0) res_r[8*ch +: 8] <= 8'd0;
        else begin
          c = AC'(acc) >> FRAC_BITS;
          res_r[8*ch +: 8] <= (c > AC'(255)) ? 8'hFF : c[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= '0; ob_wp_r <= 1'b0; ob_rp_r <= 1'b0;
    end else begin
      if (adv && vld_r[2]) ob_wp_r <= !ob_wp_r;
      if (out_valid && out_ready) ob_rp_r <= !ob_rp_r;
      ob_cnt_r <= ob_cnt_r + 2'(adv && vld_r[2]) - 2'(out_valid && out_ready);
    end
    if (adv && vld_r[2]) ob_r[ob_wp_r] <= res_r;
  end

  assign out_valid = ob_cnt_r != 0;
  assign out_color = ob_r[ob_rp_r];

  `BTS_ASSERT(a_q_bound, cnt_r <= (QW+1)'(QD) && inflight <= (QW+1)'(QD), "queue overflow")
  `BTS_ASSERT(a_ob_bound, ob_cnt_r <= 2'd2, "output buffer overflow")
  `BTS_ASSERT_NEXT(a_deq_pipe, rd_en, vld_r[0], "dequeued item lost")
endmodule

[hdl/bilinear_texture_sampler_unit.sv]
// Bilinear RGBA8888 texture sampler: one write or one sample accepted per clock.
// The front computes addresses and fractions and passes writes along in order;
// a 4-entry queue feeds the back, which applies writes and reads four RAM banks
// (each a full copy, written together) so four neighbors come out at once, then
// forms weights and blends. Throughput is one item per cycle while out_ready
// holds. Output stalls back up the pipe, then the queue, then in_ready.
// Depends on bts_pkg, bts_front, bts_back, bts_ram.
module bilinear_texture_sampler_unit import bts_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [IDX_W-1:0]   in_texel_index,
  input  logic [TEXEL_W-1:0] in_texel_data,
  input  logic [COORD_W-1:0] in_u_coord,
  input  logic [COORD_W-1:0] in_v_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TEXEL_W-1:0] out_sample_color,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);
  localparam int AW = $clog2(STORE_DEPTH);
  logic [CFG_W-1:0] width_r, height_r;
  logic q_valid, q_ready, f_ready;
  logic q_func;
  logic [IDX_W-1:0] q_idx;
  logic [TEXEL_W-1:0] q_data;
  logic [4*AW-1:0] q_addr;
  logic [FRAC_BITS:0] q_fx, q_fy;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_W'(64); height_r <= CFG_W'(64);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  bts_front #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid && q_ready), .in_ready(f_ready),
    .in_func(in_func), .in_texel_index(in_texel_index), .in_texel_data(in_texel_data),
    .in_u(in_u_coord), .in_v(in_v_coord),
    .width(width_r), .height(height_r), .q_valid(q_valid), .q_ready(q_ready),
    .q_func(q_func), .q_idx(q_idx), .q_data(q_data),
    .q_addr(q_addr), .q_fx(q_fx), .q_fy(q_fy));

  assign in_ready = f_ready && q_ready;

  bts_back #(.FRAC_BITS(FRAC_BITS), .STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_func(q_func), .q_idx(q_idx),
    .q_data(q_data), .q_addr(q_addr), .q_fx(q_fx), .q_fy(q_fy),
    .out_valid(out_valid), .out_ready(out_ready), .out_color(out_sample_color));
endmodule

[sim/bilinear_texture_sampler_unit_checker.sv]
`timescale 1ns / 100ps
// Checker for the bilinear texture sampler: watches all three channels,
// predicts filtered colors from its own texel copy and compares them.
// Depends on bts_pkg.
module bilinear_texture_sampler_unit_checker import bts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic [IDX_W-1:0]   in_texel_index,
  input  logic [TEXEL_W-1:0] in_texel_data,
  input  logic [COORD_W-1:0] in_u_coord,
  input  logic [COORD_W-1:0] in_v_coord,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [TEXEL_W-1:0] out_sample_color,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 err_count,
  output int                 pending
);
  localparam longint ONE  = 64'sd65536;
  localparam longint HALF = 64'sd32768;

  logic [TEXEL_W-1:0] texels [STORE_DEPTH_DEF];
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [TEXEL_W-1:0] color_queue [$];

  function automatic int used_size(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
    return r;
  endfunction

  // Position = coord*size - 1/2; fraction keeps its sign when position < 0.
  function automatic void find_neighbors(input logic [COORD_W-1:0] c, input int size,
                                         output int i0, output int i1,
                                         output longint frac);
    longint pos;
    pos = longint'(c) * size - HALF;
    if (pos < 0) begin
      i0 = 0;
      frac = pos;
    end else begin
      i0 = int'(pos / ONE);
      frac = pos - longint'(i0) * ONE;
    end
    if (i0 > size - 1) i0 = size - 1;
    i1 = (i0 + 1 == size) ? 0 : i0 + 1;
  endfunction

  // Signed division truncates toward zero, as the weights need.
  function automatic longint weight_mul(longint a, longint b);
    return (a * b) / ONE;
  endfunction

  function automatic logic [TEXEL_W-1:0] filtered_color(logic [COORD_W-1:0] u,
                                                        logic [COORD_W-1:0] v);
    int w, h, x0, x1, y0, y1;
    longint fx, fy, acc, c;
    longint wt [4];
    logic [TEXEL_W-1:0] tx [4];
    logic [TEXEL_W-1:0] color;
    w = used_size(width_reg);
    h = used_size(height_reg);
    find_neighbors(u, w, x0, x1, fx);
    find_neighbors(v, h, y0, y1, fy);
    tx[0] = texels[(y0 * w + x0) % STORE_DEPTH_DEF];
    tx[1] = texels[(y0 * w + x1) % STORE_DEPTH_DEF];
    tx[2] = texels[(y1 * w + x0) % STORE_DEPTH_DEF];
    tx[3] = texels[(y1 * w + x1) % STORE_DEPTH_DEF];
    wt[0] = weight_mul(ONE - fx, ONE - fy);
    wt[1] = weight_mul(fx, ONE - fy);
    wt[2] = weight_mul(ONE - fx, fy);
    wt[3] = weight_mul(fx, fy);
    color = '0;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += longint'(tx[k][8*ch +: 8]) * wt[k];
      if (acc <= 0) c = 0;
      else begin
        c = acc / ONE;
        if (c > 255) c = 255;
      end
      color[8*ch +: 8] = c[7:0];
    end
    return color;
  endfunction

  task automatic report_mismatch(string what, logic [TEXEL_W-1:0] got,
                                 logic [TEXEL_W-1:0] want);
    $display("%0t: %s: sample_color got %08h want %08h", $realtime, what, got, want);
    err_count++;
  endtask

  initial err_count = 0;
  assign pending = color_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  <= 7'd64;
      height_reg <= 7'd64;
      color_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (color_queue.size() == 0) report_mismatch("unexpected result", out_sample_color, '0);
        else if (out_sample_color !== color_queue[0])
          report_mismatch("wrong color", out_sample_color, color_queue.pop_front());
        else void'(color_queue.pop_front());
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_WRITE) texels[in_texel_index] <= in_texel_data;
        else color_queue.push_back(filtered_color(in_u_coord, in_v_coord));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_reg <= cfg_data;
        else height_reg <= cfg_data;
      end
    end
  end
endmodule

[sim/bilinear_texture_sampler_unit_test.sv]
`timescale 1ns / 100ps
// Testbench top for the bilinear texture sampler: clock, reset, stimulus, verdict.
// Depends on bts_pkg, bilinear_texture_sampler_unit and its checker.
module bilinear_texture_sampler_unit_test;
  import bts_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // Texels filled up front; sizes are kept so samples stay inside this range.
  localparam int FILL_COUNT = 256;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic [IDX_W-1:0]   in_texel_index;
  logic [TEXEL_W-1:0] in_texel_data;
  logic [COORD_W-1:0] in_u_coord;
  logic [COORD_W-1:0] in_v_coord;
  logic               out_valid;
  logic               out_ready;
  logic [TEXEL_W-1:0] out_sample_color;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int                 err_count;
  int                 pending;
  int                 cycles;
  int                 stall_left;
  bit                 calm;
  logic [CFG_W-1:0]   cfg_w, cfg_h;

  bilinear_texture_sampler_unit u_top (.*);

  bilinear_texture_sampler_unit_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("bilinear_texture_sampler_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, none once calm.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  task automatic send_item(logic func, logic [IDX_W-1:0] idx, logic [TEXEL_W-1:0] data,
                           logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_texel_index <= idx;
    in_texel_data  <= data;
    in_u_coord     <= u;
    in_v_coord     <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    for (int k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (k == 0) ? CFG_WIDTH : CFG_HEIGHT;
      cfg_data  <= (k == 0) ? w : h;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int used_dim(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (int'(r) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(r);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return COORD_W'($urandom_range(0, 2047));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    send_item(FUNC_SAMPLE, IDX_W'($urandom), $urandom, u, v);
  endtask

  logic [CFG_W-1:0] sizes [12];

  initial begin
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_WRITE;
    in_texel_index = '0;
    in_texel_data = '0;
    in_u_coord = '0;
    in_v_coord = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the low texels first; every size used keeps samples inside them.
    for (int i = 0; i < FILL_COUNT; i++)
      send_item(FUNC_WRITE, IDX_W'(i), $urandom, COORD_W'($urandom), COORD_W'($urandom));
    write_size(7'd64, 7'd4);

    // Directed: saturation, coordinate extremes, negative fractions, edge wrap.
    send_item(FUNC_WRITE, IDX_W'(0), 32'hFFFF_FFFF, '0, '0);
    send_item(FUNC_WRITE, IDX_W'(1), 32'h0000_0000, '1, '1);
    send_item(FUNC_WRITE, IDX_W'(FILL_COUNT - 1), 32'hFFFF_FFFF, '0, '0);
    sample('0, '0);
    sample('1, '1);
    sample('0, '1);
    sample('1, '0);
    sample(16'h8000, 16'h8000);
    sample(16'h0001, 16'h0200);
    sample(16'h0400, 16'h0000);
    write_size(7'd1, 7'd1);
    sample('0, '0);
    sample('1, 16'h8000);
    write_size(7'd0, 7'd127);
    sample('1, '1);
    sample(16'h0100, 16'hFF00);
    write_size(7'd127, 7'd0);
    sample('1, '0);
    sample(16'h7FFF, 16'h8001);
    write_size(7'd2, 7'd64);
    sample('1, '1);
    sample('0, 16'h4000);

    sizes = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd33, 7'd63, 7'd65,
              7'd7, 7'd16, 7'd4, 7'd3};
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 6) begin
        cfg_w = 7'd64;
        cfg_h = 7'd4;
      end else begin
        do begin
          cfg_w = (phase == 7) ? CFG_W'($urandom) : sizes[$urandom_range(0, 11)];
          cfg_h = (phase == 7) ? CFG_W'($urandom) : sizes[$urandom_range(0, 11)];
        end while (used_dim(cfg_w) * used_dim(cfg_h) > FILL_COUNT);
      end
      write_size(cfg_w, cfg_h);
      if (phase == 7) calm = 1'b1;
      for (int n = 0; n < 64; n++) begin
        if ($urandom_range(0, 9) < 4)
          send_item(FUNC_WRITE, IDX_W'($urandom), $urandom, COORD_W'($urandom),
                    COORD_W'($urandom));
        else sample(pick_coord(), pick_coord());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("bilinear_texture_sampler_unit_test OK");
    else $display("bilinear_texture_sampler_unit_test NOT OK");
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/bts_front.sv
hdl/bts_back.sv
hdl/bilinear_texture_sampler_unit.sv
sim/bilinear_texture_sampler_unit_checker.sv
sim/bilinear_texture_sampler_unit_test.sv
